FILE: src/alarm_match_pulse_pattern_macros.svh
// Assertion macros for the alarm pulse-pattern checker.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ALARM_MATCH_PULSE_PATTERN_MACROS_SVH
`define ALARM_MATCH_PULSE_PATTERN_MACROS_SVH

// Check a property on every rising edge outside reset.
`define AMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication that is gated by a result beat being shown.
`define AMP_ASSERT_OUT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (out_valid |-> (prop))) else $error(msg);

`endif

FILE: src/amp_pkg.sv
// Shared types, codes and pattern tables for the alarm pulse-pattern block.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package amp_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  // Tone codes
  localparam logic [1:0] TONE_SHORT  = 2'd0;
  localparam logic [1:0] TONE_DOUBLE = 2'd1;
  localparam logic [1:0] TONE_URGENT = 2'd2;
  localparam logic [1:0] TONE_PHONE  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] REG_ENABLED = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HOUR    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MINUTE  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TONE    = 2'd3;

  localparam logic [4:0] MAX_HOUR   = 5'd23;
  localparam logic [5:0] MAX_MINUTE = 6'd59;
  localparam logic [7:0] FIRE_SECOND_LIMIT = 8'd2;

  localparam int unsigned GapW = 12;
  localparam logic [GapW-1:0] PAUSE_URGENT_MS = 12'd1200;
  localparam logic [GapW-1:0] PAUSE_OTHER_MS  = 12'd2500;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] day_number;
    logic [7:0]  time_hour;
    logic [7:0]  time_minute;
    logic [7:0]  time_second;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic vibrate_pulse;
    logic alarm_fired;
    logic phone_sound;
    logic is_ringing;
  } out_item_t;

  typedef struct packed {
    logic       enabled;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [1:0] tone;
  } cfg_t;

  function automatic logic [3:0] tone_pulse_count(input logic [1:0] tone);
    logic [3:0] cnt;
    case (tone)
      TONE_SHORT:  cnt = 4'd2;
      TONE_DOUBLE: cnt = 4'd6;
      TONE_URGENT: cnt = 4'd14;
      default:     cnt = 4'd3;
    endcase
    return cnt;
  endfunction

  // True where p mod 3 is 2, for a 4-bit pulse index
  function automatic logic idx_mod3_is2(input logic [3:0] p);
    logic hit;
    case (p)
      4'd2, 4'd5, 4'd8, 4'd11, 4'd14: hit = 1'b1;
      default:                        hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [GapW-1:0] tone_gap(input logic [1:0] tone, input logic [3:0] p);
    logic [GapW-1:0] gap;
    case (tone)
      TONE_URGENT: gap = idx_mod3_is2(p) ? 12'd650 : 12'd160;
      TONE_DOUBLE: gap = p[0] ? 12'd700 : 12'd220;
      TONE_SHORT:  gap = 12'd500;
      default:     gap = 12'd750;
    endcase
    return gap;
  endfunction

endpackage

`default_nettype wire

FILE: src/alarm_match_pulse_pattern.sv
// Top level of the alarm pulse-pattern block: input register, ringing control,
// result register. Depends on amp_pkg, amp_cfg_regs and amp_ring_ctrl.
//
//   channel | ports                          | beat
//   --------+--------------------------------+------------------------------
//   input   | in_valid, in_ready, in_data    | one command with time fields
//   result  | out_valid, out_ready, out_data | one pulse/status word per item
//   config  | cfg_we, cfg_idx, cfg_wdata     | one register write, no wait
//
// An item passes the input register, then the result register. One item is taken
// every cycle while the result side does not stall, with the compare-and-add logic between the two.
// Reset (rst_n low, synchronous) clears the ringing state, the configuration registers
// and both stage valids. A stalled result holds; the input register still fills behind it.
`default_nettype none

module alarm_match_pulse_pattern (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire amp_pkg::in_item_t            in_data,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output amp_pkg::out_item_t                out_data,
  input  wire logic                         cfg_we,
  input  wire logic [amp_pkg::CfgIdxW-1:0]  cfg_idx,
  input  wire logic [amp_pkg::CfgDataW-1:0] cfg_wdata
);

  amp_pkg::cfg_t      cfg;
  amp_pkg::in_item_t  s1_data_r;
  logic               s1_vld_r;
  amp_pkg::out_item_t out_data_r;
  logic               out_vld_r;
  amp_pkg::out_item_t step_result;
  logic               out_free;
  logic               advance;

  assign out_free = !out_vld_r || out_ready;
  assign advance  = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || out_free;

  amp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  amp_ring_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s1_data_r),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: src/amp_cfg_regs.sv
// Configuration registers of the alarm block; an out-of-range hour or minute stores zero.
// Depends on amp_pkg.
`default_nettype none

module amp_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [amp_pkg::CfgIdxW-1:0]  cfg_idx,
  input  wire logic [amp_pkg::CfgDataW-1:0] cfg_wdata,
  output amp_pkg::cfg_t                     cfg
);

  amp_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        amp_pkg::REG_ENABLED: cfg_nxt.enabled = cfg_wdata[0];
        amp_pkg::REG_HOUR: begin
          // out-of-range hour stores zero
          cfg_nxt.hour = (cfg_wdata[4:0] > amp_pkg::MAX_HOUR) ? 5'd0 : cfg_wdata[4:0];
        end
        amp_pkg::REG_MINUTE: begin
          cfg_nxt.minute = (cfg_wdata > amp_pkg::MAX_MINUTE) ? 6'd0 : cfg_wdata;
        end
        amp_pkg::REG_TONE: cfg_nxt.tone = cfg_wdata[1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: src/amp_ring_ctrl.sv
// Ringing state and per-item decision: trigger match, pulse spacing and pause.
// Depends on amp_pkg. State advances only when the top level moves a beat on.
`default_nettype none

module amp_ring_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  wire amp_pkg::in_item_t item,
  input  wire amp_pkg::cfg_t     cfg,
  output amp_pkg::out_item_t result
);

  logic        ringing_r, ringing_nxt;
  logic [3:0]  pulse_idx_r, pulse_idx_nxt;
  logic [31:0] next_time_r, next_time_nxt;
  logic [15:0] fired_day_r, fired_day_nxt;
  logic        fired_vld_r, fired_vld_nxt;

  logic                     due;
  logic                     match;
  logic                     pattern_done;
  logic [amp_pkg::GapW-1:0] step_ms;

  assign due = item.now_ms >= next_time_r;
  assign match = cfg.enabled && !ringing_r
              && (item.time_hour == {3'd0, cfg.hour})
              && (item.time_minute == {2'd0, cfg.minute})
              && (item.time_second < amp_pkg::FIRE_SECOND_LIMIT)
              && (!fired_vld_r || (fired_day_r != item.day_number));
  assign pattern_done = pulse_idx_r >= amp_pkg::tone_pulse_count(cfg.tone);

  always_comb begin
    if (pattern_done) begin
      step_ms = (cfg.tone == amp_pkg::TONE_URGENT) ? amp_pkg::PAUSE_URGENT_MS
                                                   : amp_pkg::PAUSE_OTHER_MS;
    end else begin
      step_ms = amp_pkg::tone_gap(cfg.tone, pulse_idx_r);
    end
  end

  always_comb begin
    ringing_nxt   = ringing_r;
    pulse_idx_nxt = pulse_idx_r;
    next_time_nxt = next_time_r;
    fired_day_nxt = fired_day_r;
    fired_vld_nxt = fired_vld_r;
    result        = '0;
    case (item.cmd)
      amp_pkg::CMD_STOP: begin
        ringing_nxt   = 1'b0;
        pulse_idx_nxt = 4'd0;
        next_time_nxt = 32'd0;
      end
      amp_pkg::CMD_TICK: begin
        if (match) begin
          fired_day_nxt      = item.day_number;
          fired_vld_nxt      = 1'b1;
          ringing_nxt        = 1'b1;
          pulse_idx_nxt      = 4'd0;
          next_time_nxt      = item.now_ms;
          result.alarm_fired = 1'b1;
          result.phone_sound = cfg.tone == amp_pkg::TONE_PHONE;
        end
      end
      amp_pkg::CMD_UPDATE: begin
        if (ringing_r && due) begin
          // sum wraps mod 2^32
          next_time_nxt = item.now_ms + {20'd0, step_ms};
          if (pattern_done) begin
            pulse_idx_nxt = 4'd0;
          end else begin
            result.vibrate_pulse = 1'b1;
            pulse_idx_nxt        = pulse_idx_r + 4'd1;
          end
        end
      end
      default: begin
        ringing_nxt = ringing_r;
      end
    endcase
    result.is_ringing = ringing_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ringing_r   <= 1'b0;
      pulse_idx_r <= 4'd0;
      next_time_r <= 32'd0;
      fired_vld_r <= 1'b0;
    end else if (advance) begin
      ringing_r   <= ringing_nxt;
      pulse_idx_r <= pulse_idx_nxt;
      next_time_r <= next_time_nxt;
      fired_vld_r <= fired_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fired_day_r <= fired_day_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/amp_checker.sv
// Port-level checks for the alarm pulse-pattern block, bound to the top level.
// Depends on amp_pkg and alarm_match_pulse_pattern_macros.svh.
`default_nettype none
`include "alarm_match_pulse_pattern_macros.svh"

module amp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire amp_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire amp_pkg::out_item_t out_data
);

  `AMP_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data), "stalled input beat changed")
  `AMP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result beat changed")
  `AMP_ASSERT_OUT(a_fire_rings, !out_data.alarm_fired || out_data.is_ringing, "fired without ringing")
  `AMP_ASSERT_OUT(a_phone_fire, !out_data.phone_sound || out_data.alarm_fired, "phone sound without trigger")
  `AMP_ASSERT_OUT(a_vib_rings, !out_data.vibrate_pulse || (out_data.is_ringing && !out_data.alarm_fired), "vibrate outside ringing")

endmodule

bind alarm_match_pulse_pattern amp_checker u_amp_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench for alarm_match_pulse_pattern: a directed table, then random ring sessions.
// Predicts each result beat in-line or takes it from the directed table, and checks it field by field at the output.
// Depends on amp_pkg and the RTL top level only.

module testbench;

  localparam logic [1:0]  CMD_UNUSED       = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned PHASE_ITEMS      = 342;
  localparam int unsigned MAX_PRINTED      = 60;

  localparam logic [31:0] GAP_SHORT_MS      = 32'd500;
  localparam logic [31:0] GAP_DOUBLE_ODD_MS = 32'd700;
  localparam logic [31:0] GAP_DOUBLE_EVN_MS = 32'd220;
  localparam logic [31:0] GAP_URGENT_LONG   = 32'd650;
  localparam logic [31:0] GAP_URGENT_SHORT  = 32'd160;
  localparam logic [31:0] GAP_PHONE_MS      = 32'd750;

  // Result words: {vibrate, fired, phone, ringing}
  localparam amp_pkg::out_item_t QUIET       = 4'b0000;
  localparam amp_pkg::out_item_t RING_ONLY   = 4'b0001;
  localparam amp_pkg::out_item_t FIRED_PLAIN = 4'b0101;
  localparam amp_pkg::out_item_t FIRED_PHONE = 4'b0111;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                         kind;
    amp_pkg::in_item_t                 beat;
    logic                              typed;
    amp_pkg::out_item_t                want;
    logic [3:0][amp_pkg::CfgDataW-1:0] regs;
  } dir_row_t;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  amp_pkg::in_item_t            in_data   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  amp_pkg::out_item_t           out_data;
  logic                         cfg_we    = 1'b0;
  logic [amp_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [amp_pkg::CfgDataW-1:0] cfg_wdata = '0;

  // Predicted register and ringing state
  logic        arm_en;
  logic [4:0]  arm_hour;
  logic [5:0]  arm_minute;
  logic [1:0]  tone_sel;
  logic        ring_on;
  logic [3:0]  pulse_idx;
  logic [31:0] next_pulse;
  logic [15:0] fired_day;
  logic        fired_ok;

  amp_pkg::out_item_t expected_q[$];
  dir_row_t           dir_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;
  int unsigned hold_left      = 0;
  logic        long_hold_req  = 1'b0;

  alarm_match_pulse_pattern u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [3:0] round_length(input logic [1:0] tone);
    case (tone)
      amp_pkg::TONE_SHORT:  return 4'd2;
      amp_pkg::TONE_DOUBLE: return 4'd6;
      amp_pkg::TONE_URGENT: return 4'd14;
      default:              return 4'd3;
    endcase
  endfunction

  function automatic logic [31:0] gap_after(input logic [1:0] tone, input logic [3:0] p);
    case (tone)
      amp_pkg::TONE_URGENT: return (p % 3 == 2) ? GAP_URGENT_LONG : GAP_URGENT_SHORT;
      amp_pkg::TONE_DOUBLE: return (p % 2 == 1) ? GAP_DOUBLE_ODD_MS : GAP_DOUBLE_EVN_MS;
      amp_pkg::TONE_SHORT:  return GAP_SHORT_MS;
      default:              return GAP_PHONE_MS;
    endcase
  endfunction

  task automatic advance_alarm(input amp_pkg::in_item_t b, output amp_pkg::out_item_t r);
    r = QUIET;
    case (b.cmd)
      amp_pkg::CMD_STOP: begin
        ring_on    = 1'b0;
        pulse_idx  = '0;
        next_pulse = '0;
      end
      amp_pkg::CMD_TICK: begin
        if (arm_en && !ring_on && b.time_hour == {3'b000, arm_hour} &&
            b.time_minute == {2'b00, arm_minute} &&
            b.time_second < amp_pkg::FIRE_SECOND_LIMIT &&
            (!fired_ok || fired_day != b.day_number)) begin
          fired_day     = b.day_number;
          fired_ok      = 1'b1;
          ring_on       = 1'b1;
          pulse_idx     = '0;
          next_pulse    = b.now_ms;
          r.alarm_fired = 1'b1;
          r.phone_sound = (tone_sel == amp_pkg::TONE_PHONE);
        end
      end
      amp_pkg::CMD_UPDATE: begin
        if (ring_on && b.now_ms >= next_pulse) begin
          if (pulse_idx >= round_length(tone_sel)) begin
            // end of a round: pause before the pattern repeats
            pulse_idx  = '0;
            next_pulse = b.now_ms + ((tone_sel == amp_pkg::TONE_URGENT)
                                     ? 32'(amp_pkg::PAUSE_URGENT_MS)
                                     : 32'(amp_pkg::PAUSE_OTHER_MS));
          end else begin
            r.vibrate_pulse = 1'b1;
            next_pulse      = b.now_ms + gap_after(tone_sel, pulse_idx);
            pulse_idx       = pulse_idx + 4'd1;
          end
        end
      end
      default: ;
    endcase
    r.is_ringing = ring_on;
  endtask

  function automatic amp_pkg::in_item_t noise_beat(input logic [1:0] cmd);
    amp_pkg::in_item_t b;
    b.cmd         = cmd;
    b.day_number  = 16'($urandom);
    b.time_hour   = 8'($urandom);
    b.time_minute = 8'($urandom);
    b.time_second = 8'($urandom);
    b.now_ms      = $urandom;
    return b;
  endfunction

  function automatic dir_row_t beat_row(input logic [1:0] cmd, input logic [15:0] day,
                                        input logic [7:0] hr, input logic [7:0] mn,
                                        input logic [7:0] sc, input logic [31:0] stamp,
                                        input logic typed, input amp_pkg::out_item_t want);
    dir_row_t r;
    r.kind             = ROW_BEAT;
    r.beat.cmd         = cmd;
    r.beat.day_number  = day;
    r.beat.time_hour   = hr;
    r.beat.time_minute = mn;
    r.beat.time_second = sc;
    r.beat.now_ms      = stamp;
    r.typed            = typed;
    r.want             = want;
    r.regs             = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [amp_pkg::CfgDataW-1:0] en,
                                       input logic [amp_pkg::CfgDataW-1:0] hr,
                                       input logic [amp_pkg::CfgDataW-1:0] mn,
                                       input logic [amp_pkg::CfgDataW-1:0] tone);
    dir_row_t r;
    r.kind                       = ROW_CFG;
    r.beat                       = '0;
    r.typed                      = 1'b0;
    r.want                       = QUIET;
    r.regs[amp_pkg::REG_ENABLED] = en;
    r.regs[amp_pkg::REG_HOUR]    = hr;
    r.regs[amp_pkg::REG_MINUTE]  = mn;
    r.regs[amp_pkg::REG_TONE]    = tone;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED)
      $display("[%0t] mismatch on result beat %0d: %s", $time, results_seen, what);
    mismatch_count++;
  endtask

  task automatic check_result(input amp_pkg::out_item_t got);
    amp_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      flag_mismatch($sformatf("no prediction pending, got %b", got));
    end else begin
      want = expected_q.pop_front();
      if (got.vibrate_pulse !== want.vibrate_pulse)
        flag_mismatch($sformatf("vibrate_pulse %b, want %b", got.vibrate_pulse,
                                want.vibrate_pulse));
      if (got.alarm_fired !== want.alarm_fired)
        flag_mismatch($sformatf("alarm_fired %b, want %b", got.alarm_fired, want.alarm_fired));
      if (got.phone_sound !== want.phone_sound)
        flag_mismatch($sformatf("phone_sound %b, want %b", got.phone_sound, want.phone_sound));
      if (got.is_ringing !== want.is_ringing)
        flag_mismatch($sformatf("is_ringing %b, want %b", got.is_ringing, want.is_ringing));
    end
    results_seen++;
  endtask

  // Result side: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_result(out_data);
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        hold_left     <= LONG_HOLD_CYCLES;
        out_ready     <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_beat(input amp_pkg::in_item_t beat, input logic typed,
                           input amp_pkg::out_item_t want);
    amp_pkg::out_item_t pred;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    advance_alarm(beat, pred);
    expected_q.push_back(typed ? want : pred);
    if (beat.cmd != CMD_UNUSED) items_sent++;
  endtask

  // Hold the input until every predicted beat has come out, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [amp_pkg::CfgIdxW-1:0] idx,
                           input logic [amp_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      amp_pkg::REG_ENABLED: arm_en     = val[0];
      amp_pkg::REG_HOUR:    arm_hour   = (val[4:0] > amp_pkg::MAX_HOUR) ? 5'd0 : val[4:0];
      amp_pkg::REG_MINUTE:  arm_minute = (val > amp_pkg::MAX_MINUTE) ? 6'd0 : val;
      amp_pkg::REG_TONE:    tone_sel   = val[1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [amp_pkg::CfgDataW-1:0] en,
                           input logic [amp_pkg::CfgDataW-1:0] hr,
                           input logic [amp_pkg::CfgDataW-1:0] mn,
                           input logic [amp_pkg::CfgDataW-1:0] tone);
    drain_results();
    write_reg(amp_pkg::REG_ENABLED, en);
    write_reg(amp_pkg::REG_HOUR, hr);
    write_reg(amp_pkg::REG_MINUTE, mn);
    write_reg(amp_pkg::REG_TONE, tone);
    cfg_we <= 1'b0;
  endtask

  // One ring: configure, optional stop, tick at the alarm time, updates on a mostly rising clock, optional stop
  task automatic ring_session(input bit hold_off);
    amp_pkg::in_item_t b;
    logic [31:0]       stamp;
    int unsigned       pick;
    configure({5'($urandom), ($urandom_range(0, 9) != 0)},
              ($urandom_range(0, 7) == 0) ? 6'($urandom)
                                          : {1'($urandom), 5'($urandom_range(0, 23))},
              ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59)),
              6'($urandom));
    if (hold_off) long_hold_req <= 1'b1;
    if ($urandom_range(0, 5) != 0) send_beat(noise_beat(amp_pkg::CMD_STOP), 1'b0, QUIET);
    b             = noise_beat(amp_pkg::CMD_TICK);
    b.time_hour   = {3'b000, arm_hour};
    b.time_minute = {2'b00, arm_minute};
    b.time_second = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
    if ($urandom_range(0, 5) == 0) b.day_number = fired_day;
    if ($urandom_range(0, 3) == 0) b.now_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
    stamp = b.now_ms;
    send_beat(b, 1'b0, QUIET);
    repeat ($urandom_range(12, 48)) begin
      pick = $urandom_range(0, 19);
      if (pick == 4) begin
        send_beat(noise_beat(2'($urandom)), 1'b0, QUIET);
      end else begin
        case (pick)
          0:       stamp = stamp + $urandom_range(2400, 2600);
          1:       stamp = $urandom;
          2, 3:    stamp = stamp + $urandom_range(0, 150);
          default: stamp = stamp + $urandom_range(150, 800);
        endcase
        b        = noise_beat(amp_pkg::CMD_UPDATE);
        b.now_ms = stamp;
        send_beat(b, 1'b0, QUIET);
      end
    end
    if ($urandom_range(0, 7) != 0) send_beat(noise_beat(amp_pkg::CMD_STOP), 1'b0, QUIET);
  endtask

  initial begin
    int unsigned session;
    arm_en     = 1'b0;
    arm_hour   = '0;
    arm_minute = '0;
    tone_sel   = amp_pkg::TONE_SHORT;
    ring_on    = 1'b0;
    pulse_idx  = '0;
    next_pulse = '0;
    fired_day  = '0;
    fired_ok   = 1'b0;

    // Disarmed block, unused command, update and stop while silent
    dir_rows.push_back(beat_row(amp_pkg::CMD_TICK, 16'h0000, 8'd0, 8'd0, 8'd0, 32'd0,
                                1'b1, QUIET));
    dir_rows.push_back(beat_row(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
                                1'b1, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_UPDATE, 16'h0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF,
                                1'b1, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_STOP, 16'h0, 8'd0, 8'd0, 8'd0, 32'd0,
                                1'b1, QUIET));
    // Out-of-range hour and minute fold to 0:00
    dir_rows.push_back(cfg_row(6'd1, 6'd63, 6'd63, 6'(amp_pkg::TONE_PHONE)));
    dir_rows.push_back(beat_row(amp_pkg::CMD_TICK, 16'h0000, 8'd0, 8'd0, 8'd2, 32'd0,
                                1'b1, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_TICK, 16'hFFFF, 8'd0, 8'd0, 8'd1, 32'hFFFF_FF00,
                                1'b1, FIRED_PHONE));
    dir_rows.push_back(beat_row(amp_pkg::CMD_TICK, 16'h0001, 8'd0, 8'd0, 8'd0, 32'd0,
                                1'b1, RING_ONLY));
    // Pulse times wrap past 2^32
    dir_rows.push_back(beat_row(amp_pkg::CMD_UPDATE, 16'h0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FF00,
                                1'b0, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_UPDATE, 16'h0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF,
                                1'b0, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_UPDATE, 16'h0, 8'd0, 8'd0, 8'd0, 32'd0,
                                1'b0, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_UPDATE, 16'h0, 8'd0, 8'd0, 8'd0, 32'h0000_02ED,
                                1'b0, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_UPDATE, 16'h0, 8'd0, 8'd0, 8'd0, 32'h0000_05DB,
                                1'b0, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_STOP, 16'h0, 8'd0, 8'd0, 8'd0, 32'd0,
                                1'b1, QUIET));
    // Same day may not fire twice; a new day does
    dir_rows.push_back(beat_row(amp_pkg::CMD_TICK, 16'hFFFF, 8'd0, 8'd0, 8'd0, 32'd0,
                                1'b1, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_TICK, 16'h0000, 8'd0, 8'd0, 8'd0, 32'd0,
                                1'b1, FIRED_PHONE));
    // Disarm while ringing: the ring goes on
    dir_rows.push_back(cfg_row(6'd0, 6'd24, 6'd60, 6'(amp_pkg::TONE_PHONE)));
    dir_rows.push_back(beat_row(amp_pkg::CMD_UPDATE, 16'h0, 8'd0, 8'd0, 8'd0, 32'd0,
                                1'b0, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_STOP, 16'h0, 8'd0, 8'd0, 8'd0, 32'd0,
                                1'b1, QUIET));
    dir_rows.push_back(cfg_row(6'd1, 6'd23, 6'd59, 6'(amp_pkg::TONE_URGENT)));
    dir_rows.push_back(beat_row(amp_pkg::CMD_TICK, 16'h0002, 8'd23, 8'd59, 8'd1, 32'd0,
                                1'b1, FIRED_PLAIN));
    dir_rows.push_back(beat_row(amp_pkg::CMD_TICK, 16'h0003, 8'hFF, 8'hFF, 8'hFF, 32'd0,
                                1'b1, RING_ONLY));
    dir_rows.push_back(beat_row(amp_pkg::CMD_UPDATE, 16'h0, 8'd0, 8'd0, 8'd0, 32'd100,
                                1'b0, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_UPDATE, 16'h0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF,
                                1'b0, QUIET));
    dir_rows.push_back(beat_row(amp_pkg::CMD_STOP, 16'h0, 8'd0, 8'd0, 8'd0, 32'd0,
                                1'b1, QUIET));

    repeat (4) @(posedge clk);
    rst_n          <= 1'b1;
    send_idle_pct  = 15;
    recv_stall_pct <= 78;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        configure(dir_rows[i].regs[amp_pkg::REG_ENABLED], dir_rows[i].regs[amp_pkg::REG_HOUR],
                  dir_rows[i].regs[amp_pkg::REG_MINUTE], dir_rows[i].regs[amp_pkg::REG_TONE]);
      else
        send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 15;
          recv_stall_pct <= 78;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct <= 15;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
      endcase
      items_sent = 0;
      session    = 0;
      while (items_sent < PHASE_ITEMS) begin
        ring_session(session == 1);
        session++;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
